FILE: src/rps_pkg.sv
// ----------------------------------------------------------------------------
// Radix partition scatter package
// Shared types, register indexes and default sizes of the radix partitioner.
// ----------------------------------------------------------------------------
`default_nettype none

package rps_pkg;

  // Default sizes of the partitioner.
  localparam int unsigned MaxRadixBitsDef = 10;
  localparam int unsigned MaxTuplesDef    = 65536;

  // Fixed field widths.
  localparam int unsigned KeyW    = 32;
  localparam int unsigned BucketW = 10;
  localparam int unsigned SlotW   = 16;
  localparam int unsigned ShiftW  = 5;
  localparam int unsigned NbW     = 4;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_RADIX_SHIFT = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_RADIX_BITS  = 1'b1;

  // Command modes.
  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_COUNT = 2'd1,
    MODE_PLACE = 2'd2
  } mode_e;

  // One command beat.
  typedef struct packed {
    mode_e           mode;
    logic [KeyW-1:0] key_in;
    logic [KeyW-1:0] payload_in;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic [KeyW-1:0]    key_out;
    logic [KeyW-1:0]    payload_out;
    logic [BucketW-1:0] bucket;
    logic [SlotW-1:0]   slot;
    logic               overflow;
  } res_t;

  // Back end states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_READ,
    ST_WRITE
  } back_state_e;

  // Status from the back end to the front end.
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

endpackage

`default_nettype wire

FILE: src/rps_front.sv
// ----------------------------------------------------------------------------
// Radix partition front end
// Holds the radix registers, accepts commands, computes each tuple's bucket
// and queues the classified command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_front
  import rps_pkg::*;
#(
  parameter int unsigned MaxRadixBits = MaxRadixBitsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [CfgW-1:0]         cfg_data_i,
  input  wire logic                    start,
  output logic                         busy,
  input  wire cmd_t                    cmd_i,
  input  wire back_stat_t              stat_i,
  output logic                         q_valid_o,
  output cmd_t                         q_cmd_o,
  output logic [MaxRadixBits-1:0]      q_bucket_o
);

  logic [ShiftW-1:0] shift_q;
  logic [NbW-1:0]    nbits_q;

  // Radix registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      nbits_q <= NbW'(10);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIX_SHIFT: shift_q <= cfg_data_i[ShiftW-1:0];
        REG_RADIX_BITS:  nbits_q <= cfg_data_i[NbW-1:0];
        default: ;
      endcase
    end
  end

  // Bucket of the incoming key: shifted key masked to the saturated width.
  logic [NbW:0]              nb_sat;
  logic [MaxRadixBits-1:0]   mask;
  logic [KeyW-1:0]           shifted;
  logic [MaxRadixBits-1:0]   bucket;

  always_comb begin
    nb_sat = ({1'b0, nbits_q} > (NbW+1)'(MaxRadixBits)) ?
             (NbW+1)'(MaxRadixBits) : {1'b0, nbits_q};
    for (int i = 0; i < MaxRadixBits; i++) begin
      mask[i] = ((NbW+1)'(i) < nb_sat);
    end
    shifted = cmd_i.key_in >> shift_q;
    bucket  = shifted[MaxRadixBits-1:0] & mask;
  end

  // Two-entry command queue.
  cmd_t                    q_cmd_q [2];
  logic [MaxRadixBits-1:0] q_bkt_q [2];
  logic                    wptr_q, rptr_q;
  logic [1:0]              cnt_q;
  logic                    push, pop, full, mode_ok;

  assign full    = (cnt_q == 2'd2);
  assign busy    = full || stat_i.clearing;
  assign mode_ok = (cmd_i.mode == MODE_CLEAR) || (cmd_i.mode == MODE_COUNT) ||
                   (cmd_i.mode == MODE_PLACE);
  assign push    = start && !busy && mode_ok;
  assign pop     = stat_i.pop && (cnt_q != 2'd0);

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_cmd_q[wptr_q] <= cmd_i;
      q_bkt_q[wptr_q] <= bucket;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = q_cmd_q[rptr_q];
  assign q_bucket_o = q_bkt_q[rptr_q];

endmodule

`default_nettype wire

FILE: src/rps_back.sv
// ----------------------------------------------------------------------------
// Radix partition back end
// Owns the bucket count store and carries out clear sweeps, counting, the
// prefix walk and placement, one queued command at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_back
  import rps_pkg::*;
#(
  parameter int unsigned MaxRadixBits = MaxRadixBitsDef,
  parameter int unsigned MaxTuples    = MaxTuplesDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    q_valid_i,
  input  wire cmd_t                    q_cmd_i,
  input  wire logic [MaxRadixBits-1:0] q_bucket_i,
  output back_stat_t                   stat_o,
  output logic                         res_valid_o,
  output res_t                         res_o
);

  localparam int unsigned Fanout = 1 << MaxRadixBits;
  localparam int unsigned IdxW   = MaxRadixBits + 1;
  localparam int unsigned CntW   = $clog2(MaxTuples + 2);
  localparam int unsigned MemW   = (CntW > SlotW) ? CntW : SlotW;

  back_state_e             state_q, state_d;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic [MemW-1:0]         run_q, run_d;
  logic                    phase_q, phase_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  cmd_t                    cur_q;
  logic [MaxRadixBits-1:0] bkt_q;
  logic                    pop;

  // Count store with registered read.
  logic [MemW-1:0]         mem [Fanout];
  logic [MemW-1:0]         rd_data_q;
  logic                    we;
  logic [MaxRadixBits-1:0] wa, ra;
  logic [MemW-1:0]         wd;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_data_q <= mem[ra];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    run_d   = run_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    pop     = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == IdxW'(Fanout - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          pop = 1'b1;
          priority case (q_cmd_i.mode)
            MODE_CLEAR: begin
              state_d = ST_CLEAR;
              idx_d   = '0;
              phase_d = 1'b0;
              cnt_d   = '0;
            end
            MODE_COUNT: begin
              if (!phase_q) begin
                if (cnt_q >= CntW'(MaxTuples)) begin
                  cnt_d = CntW'(MaxTuples + 1);
                end else begin
                  cnt_d   = cnt_q + 1'b1;
                  state_d = ST_READ;
                end
              end
            end
            MODE_PLACE: begin
              if (phase_q) begin
                state_d = ST_READ;
              end else begin
                state_d = ST_WALK;
                idx_d   = '0;
                run_d   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        idx_d = idx_q + 1'b1;
        if (idx_q != '0) run_d = run_q + rd_data_q;
        if (idx_q == IdxW'(Fanout)) begin
          phase_d = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ:  state_d = ST_WRITE;
      ST_WRITE: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    we = 1'b0;
    wa = bkt_q;
    wd = rd_data_q + 1'b1;
    ra = bkt_q;
    unique case (state_q)
      ST_CLEAR: begin
        we = 1'b1;
        wa = idx_q[MaxRadixBits-1:0];
        wd = '0;
      end
      ST_WALK: begin
        ra = idx_q[MaxRadixBits-1:0];
        we = (idx_q != '0);
        wa = MaxRadixBits'(idx_q - 1'b1);
        wd = run_q;
      end
      ST_WRITE: we = 1'b1;
      default: ;
    endcase
  end

  assign stat_o.pop      = pop;
  assign stat_o.clearing = (state_q == ST_CLEAR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q   <= '0;
      run_q   <= '0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      run_q   <= run_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  // Current command.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= q_cmd_i;
      bkt_q <= q_bucket_i;
    end
  end

  // Result register, shown for one cycle after the update.
  logic [MaxRadixBits+BucketW-1:0] bkt_ext;
  assign bkt_ext = {BucketW'(0), bkt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= (state_q == ST_WRITE) && (cur_q.mode == MODE_PLACE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE) begin
      res_o.key_out     <= cur_q.key_in;
      res_o.payload_out <= cur_q.payload_in;
      res_o.bucket      <= bkt_ext[BucketW-1:0];
      res_o.slot        <= rd_data_q[SlotW-1:0];
      res_o.overflow    <= (cnt_q > CntW'(MaxTuples));
    end
  end

endmodule

`default_nettype wire

FILE: src/radix_partition_scatter.sv
// ----------------------------------------------------------------------------
// Radix partition scatter
// Histogram, exclusive prefix sum and scatter of one relation by radix.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; a two-deep queue
// lets the front take commands while the back end works. Count and place
// commands that touch the store pass through the back end's issue, memory read
// and update steps, set by the registered read of the count store; a count
// that is ignored (while placing, or past the tuple limit) is popped without a
// store access, and an unused mode is never queued. The first place after
// counting first walks all 2^MaxRadixBits buckets, one a cycle, and a clear
// sweeps all 2^MaxRadixBits store entries, as does the clearing pass after
// reset, during which busy stays high. Each place result is on res_o for
// exactly one cycle, marked by res_valid_o, and cannot be held off.
`default_nettype none

module radix_partition_scatter
  import rps_pkg::*;
#(
  parameter int unsigned MaxRadixBits = MaxRadixBitsDef,
  parameter int unsigned MaxTuples    = MaxTuplesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               start,
  output logic                    busy,
  input  wire cmd_t               cmd_i,
  output logic                    res_valid_o,
  output res_t                    res_o
);

  back_stat_t              stat;
  logic                    q_valid;
  cmd_t                    q_cmd;
  logic [MaxRadixBits-1:0] q_bucket;

  // Front end: registers, bucket and queue.
  rps_front #(
    .MaxRadixBits(MaxRadixBits)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .start     (start),
    .busy      (busy),
    .cmd_i     (cmd_i),
    .stat_i    (stat),
    .q_valid_o (q_valid),
    .q_cmd_o   (q_cmd),
    .q_bucket_o(q_bucket)
  );

  // Back end: count store and sequencer.
  rps_back #(
    .MaxRadixBits(MaxRadixBits),
    .MaxTuples   (MaxTuples)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_cmd),
    .q_bucket_i (q_bucket),
    .stat_o     (stat),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

`ifndef NO_ASSERTIONS
  // The back end only pops a queued command.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.pop |-> q_valid) else $error("pop from empty queue");

  // No result beat appears during a clear sweep.
  a_no_res_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !res_valid_o) else $error("result during clear");

  // Result beats never come in two consecutive cycles.
  a_res_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("back-to-back results");
`endif

endmodule

`default_nettype wire

FILE: bench/rps_checker.sv
// ----------------------------------------------------------------------------
// Radix partition scatter checker
// Watches the command, configuration and result channels of the partitioner,
// keeps its own histogram and cursor store, and compares every placed tuple.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_checker
  import rps_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               start_i,
  input  wire logic               busy_i,
  input  wire cmd_t               cmd_i,
  input  wire logic               res_valid_i,
  input  wire res_t               res_i,
  output int                      errors_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Fanout = 1 << MaxRadixBitsDef;

  // Shadow state of the partitioner.
  logic [31:0]       cursor_mem [Fanout];
  logic              placing;
  int unsigned       tuple_cnt;
  logic [ShiftW-1:0] shift_q;
  logic [NbW-1:0]    nbits_q;
  res_t              placed_q [$];

  assign pending_o = placed_q.size();

  function automatic logic [BucketW-1:0] radix_of(logic [KeyW-1:0] key);
    int unsigned nb;
    logic [31:0] mask;
    nb   = (nbits_q > MaxRadixBitsDef) ? MaxRadixBitsDef : nbits_q;
    mask = (32'd1 << nb) - 32'd1;
    return BucketW'((key >> shift_q) & mask);
  endfunction

  // Predict on every accepted command beat and every register write.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [BucketW-1:0] b;
    logic [31:0] running, c;
    res_t r;
    if (!rst_ni) begin
      foreach (cursor_mem[i]) cursor_mem[i] = '0;
      placing   = 1'b0;
      tuple_cnt = 0;
      shift_q   = '0;
      nbits_q   = NbW'(10);
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_RADIX_SHIFT) shift_q = cfg_data_i[ShiftW-1:0];
        else if (cfg_idx_i == REG_RADIX_BITS) nbits_q = cfg_data_i[NbW-1:0];
      end
      if (start_i && !busy_i) begin
        case (cmd_i.mode)
          MODE_CLEAR: begin
            foreach (cursor_mem[i]) cursor_mem[i] = '0;
            placing   = 1'b0;
            tuple_cnt = 0;
          end
          MODE_COUNT: begin
            if (!placing) begin
              if (tuple_cnt < MaxTuplesDef) begin
                b = radix_of(cmd_i.key_in);
                cursor_mem[b] = cursor_mem[b] + 1;
                tuple_cnt++;
              end else begin
                tuple_cnt = MaxTuplesDef + 1;
              end
            end
          end
          MODE_PLACE: begin
            // The first place of a relation turns counts into start offsets.
            if (!placing) begin
              running = '0;
              foreach (cursor_mem[i]) begin
                c = cursor_mem[i];
                cursor_mem[i] = running;
                running += c;
              end
              placing = 1'b1;
            end
            b = radix_of(cmd_i.key_in);
            r.key_out     = cmd_i.key_in;
            r.payload_out = cmd_i.payload_in;
            r.bucket      = b;
            r.slot        = cursor_mem[b][SlotW-1:0];
            r.overflow    = (tuple_cnt > MaxTuplesDef);
            cursor_mem[b] = cursor_mem[b] + 1;
            placed_q.push_back(r);
          end
          default: ;
        endcase
      end
    end
  end

  // Compare each result beat with the oldest expected placement.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      errors_o = 0;
    end else if (res_valid_i) begin
      if (placed_q.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, res_i);
        errors_o++;
      end else begin
        e = placed_q.pop_front();
        if (res_i.key_out !== e.key_out) begin
          $display("%0t: key_out expected %h actual %h", $time, e.key_out, res_i.key_out);
          errors_o++;
        end
        if (res_i.payload_out !== e.payload_out) begin
          $display("%0t: payload_out expected %h actual %h", $time, e.payload_out,
                   res_i.payload_out);
          errors_o++;
        end
        if (res_i.bucket !== e.bucket) begin
          $display("%0t: bucket expected %0d actual %0d", $time, e.bucket, res_i.bucket);
          errors_o++;
        end
        if (res_i.slot !== e.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, e.slot, res_i.slot);
          errors_o++;
        end
        if (res_i.overflow !== e.overflow) begin
          $display("%0t: overflow expected %b actual %b", $time, e.overflow,
                   res_i.overflow);
          errors_o++;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Radix partition scatter testbench
// Drives whole relations (clear, count, place) under several radix settings,
// plus noise; a checker predicts every placement.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import rps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam mode_e MODE_UNUSED = mode_e'(2'b11);
  localparam int    IdleWait    = 2200;
  localparam int    StallLimit  = 10000;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;
  logic               start;
  logic               busy;
  cmd_t               cmd;
  logic               res_valid;
  res_t               res;
  int                 errors, pending;
  int                 burst_left;
  int                 quiet_cycles;
  logic [KeyW-1:0]    counted_keys [$];

  radix_partition_scatter uut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .start(start), .busy(busy), .cmd_i(cmd),
    .res_valid_o(res_valid), .res_o(res)
  );

  rps_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .start_i(start), .busy_i(busy), .cmd_i(cmd),
    .res_valid_i(res_valid), .res_i(res), .errors_o(errors), .pending_o(pending)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // Watchdog: too many cycles without any accepted beat ends the run.
  always @(posedge clk) begin
    if ((start && !busy) || res_valid || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Send one command beat; returns at the edge that accepts it. Bursts of
  // random length are separated by random gaps with start low.
  task automatic send(mode_e m, logic [KeyW-1:0] k, logic [KeyW-1:0] p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    cmd   <= '{mode: m, key_in: k, payload_in: p};
    do @(posedge clk); while (busy);
  endtask

  // Hold the sender until every expected placement has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  // Registers are only written once the block has settled.
  task automatic set_radix(logic [CfgW-1:0] sh, logic [CfgW-1:0] nb);
    drain();
    repeat (IdleWait) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_RADIX_SHIFT;
    cfg_data <= sh;
    @(posedge clk);
    cfg_idx  <= REG_RADIX_BITS;
    cfg_data <= nb;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // One well-formed relation with random content; noise only if noisy.
  task automatic relation(int n_count, int n_extra, bit noisy);
    logic [KeyW-1:0] k;
    int idx;
    counted_keys.delete();
    send(MODE_CLEAR, $urandom, $urandom);
    for (int i = 0; i < n_count; i++) begin
      k = $urandom;
      if (noisy && $urandom_range(0, 15) == 0) send(MODE_UNUSED, $urandom, $urandom);
      counted_keys.push_back(k);
      send(MODE_COUNT, k, $urandom);
    end
    if ($urandom_range(0, 3) == 0) drain();
    while (counted_keys.size() != 0) begin
      idx = $urandom_range(0, counted_keys.size() - 1);
      k = counted_keys[idx];
      counted_keys.delete(idx);
      send(MODE_PLACE, k, $urandom);
      if (noisy && $urandom_range(0, 15) == 0) send(MODE_COUNT, $urandom, $urandom);
    end
    // Places beyond the counted tuples run into the next bucket's region.
    for (int i = 0; i < n_extra; i++) send(MODE_PLACE, $urandom, $urandom);
  endtask

  initial begin
    logic [CfgW-1:0] sh, nb;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = REG_RADIX_SHIFT; cfg_data = '0;
    start = 1'b0; cmd = '0;
    burst_left = 0; quiet_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every mode, the special cases.
    set_radix(5'd0, 5'd10);
    send(MODE_CLEAR, '0, '0);
    send(MODE_COUNT, '0, '1);
    send(MODE_COUNT, '1, '0);
    send(MODE_COUNT, 32'h0000_03FF, '0);
    send(MODE_UNUSED, '1, '1);
    send(MODE_PLACE, '1, '1);
    send(MODE_COUNT, 32'h1234_5678, '0);
    send(MODE_PLACE, '0, '0);
    send(MODE_PLACE, 32'h0000_03FF, 32'hA5A5_5A5A);
    send(MODE_PLACE, '0, 32'h5A5A_A5A5);
    send(MODE_PLACE, '1, '1);
    set_radix(5'd31, 5'd0);
    relation(4, 1, 1'b0);
    set_radix(5'd31, 5'd15);
    relation(4, 1, 1'b0);
    set_radix(5'd22, 5'd10);
    relation(4, 1, 1'b0);

    // Random relations under random radix settings.
    for (int ph = 0; ph < 34; ph++) begin
      sh = CfgW'($urandom_range(0, 31));
      nb = ($urandom_range(0, 3) == 0) ? CfgW'($urandom_range(0, 15)) :
                                          CfgW'($urandom_range(1, 6));
      if ($urandom_range(0, 2) != 0) set_radix(sh, nb);
      else drain();
      relation($urandom_range(4, 24), $urandom_range(0, 2), 1'b1);
    end

    // A short relation after a clear under a narrow radix.
    set_radix(5'd3, 5'd4);
    send(MODE_CLEAR, '0, '0);
    send(MODE_COUNT, 32'h0000_0008, '1);
    send(MODE_PLACE, 32'h0000_0008, '1);

    drain();
    repeat (IdleWait) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
src/rps_pkg.sv
src/rps_front.sv
src/rps_back.sv
src/radix_partition_scatter.sv
bench/rps_checker.sv
bench/tb_top.sv
